[rtl/core/sirm_pkg.sv]
`default_nettype none
package sirm_pkg;

  localparam int CAPACITY_DEF = 256;
  // wide enough for slot indexes and counts up to 4096 entries
  localparam int CTRL_W = 13;

  localparam logic signed [31:0] EMPTY_MAX = -32'sd1073741824;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
    logic [9:0]         position;
    logic [9:0]         range_low;
    logic [9:0]         range_high;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic               overflow;
  } out_beat_t;

  // broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic [CTRL_W-1:0] slot;
    logic [CTRL_W-1:0] lo;
    logic [CTRL_W-1:0] hi_excl;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/sirm_cell.sv]
`default_nettype none
module sirm_cell #(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sirm_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0] new_value,
  input  wire logic signed [31:0] prev_value,
  input  wire logic               prev_found,
  input  wire logic signed [31:0] prev_best,
  output logic signed [31:0]      value,
  output logic                    found,
  output logic signed [31:0]      best
);
  import sirm_pkg::*;

  localparam logic [CTRL_W-1:0] MY_IDX = CTRL_W'(IDX);

  logic in_range;
  logic take;

  assign in_range = (MY_IDX >= ctrl.lo) && (MY_IDX < ctrl.hi_excl);
  assign take     = in_range && (!prev_found || (value > prev_best));

  // positional insert: cells past the slot shift back by one
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX > ctrl.slot) begin
        value <= prev_value;
      end else if (MY_IDX == ctrl.slot) begin
        value <= new_value;
      end
    end
  end

  // running max ripples one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      found <= prev_found | in_range;
    end
    best <= take ? value : prev_best;
  end

endmodule
`default_nettype wire

[rtl/core/sequence_insert_range_max_core.sv]
// Ordered sequence of signed 32-bit values held one per cell in a chain of
// CAPACITY cells. Inserts may arrive back to back; the chain shifts the tail
// in the cycle after acceptance. A range-maximum query holds the input
// stalled while a running maximum ripples down the chain, one cell per
// cycle, and until the output is free; its result is then registered on the
// output; further inserts are taken while that result waits. Positions and
// ranges are 1-based and clamped to the stored count; an empty range reports
// -1073741824. Inserts into a full store are dropped and set a sticky
// overflow bit reported with each query.
`default_nettype none
module sequence_insert_range_max_core #(
  parameter int CAPACITY = sirm_pkg::CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sirm_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sirm_pkg::out_beat_t      out_beat
);
  import sirm_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      scan_cnt;
  logic               busy;
  logic               overflow_flag;
  cell_ctrl_t         ctrl;
  logic signed [31:0] new_value;

  logic               in_acc;
  logic [CTRL_W-1:0]  count_e;
  logic [CTRL_W-1:0]  pos_e;
  logic [CTRL_W-1:0]  slot_next;
  logic [CTRL_W-1:0]  lo_e;
  logic [CTRL_W-1:0]  hi_e;
  logic               full;
  logic               scan_done;

  logic signed [31:0] val_w   [CAPACITY];
  logic               found_w [CAPACITY];
  logic signed [31:0] best_w  [CAPACITY];

  assign in_stall  = busy;
  assign in_acc    = in_valid && !in_stall;
  assign count_e   = CTRL_W'(count);
  assign pos_e     = CTRL_W'(in_beat.position);
  assign lo_e      = CTRL_W'(in_beat.range_low);
  assign hi_e      = CTRL_W'(in_beat.range_high);
  assign full      = (count >= CW'(CAPACITY));
  assign scan_done = busy && (scan_cnt == CW'(CAPACITY)) && (!out_valid || !out_stall);

  always_comb begin
    slot_next = (pos_e == '0) ? '0 : (pos_e - CTRL_W'(1));
    if (slot_next > count_e) begin
      slot_next = count_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_flag <= 1'b0;
      busy          <= 1'b0;
      scan_cnt      <= '0;
      ctrl.ins      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      ctrl.ins <= in_acc && (in_beat.cmd == CMD_INSERT) && !full;
      if (in_acc) begin
        if (in_beat.cmd == CMD_INSERT) begin
          if (full) begin
            overflow_flag <= 1'b1;
          end else begin
            count <= count + CW'(1);
          end
        end else begin
          busy     <= 1'b1;
          scan_cnt <= '0;
        end
      end
      if (busy && (scan_cnt != CW'(CAPACITY))) begin
        scan_cnt <= scan_cnt + CW'(1);
      end
      if (scan_done) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    // payload side of the broadcast
    if (in_acc) begin
      ctrl.slot    <= slot_next;
      new_value    <= in_beat.value;
      ctrl.lo      <= (lo_e == '0) ? '0 : (lo_e - CTRL_W'(1));
      ctrl.hi_excl <= (hi_e > count_e) ? count_e : hi_e;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (scan_done) begin
      out_beat.max_value <= found_w[CAPACITY-1] ? best_w[CAPACITY-1] : EMPTY_MAX;
      out_beat.overflow  <= overflow_flag;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      sirm_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .new_value  (new_value),
        .prev_value (new_value),
        .prev_found (1'b0),
        .prev_best  (EMPTY_MAX),
        .value      (val_w[i]),
        .found      (found_w[i]),
        .best       (best_w[i])
      );
    end else begin : g_body
      sirm_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .new_value  (new_value),
        .prev_value (val_w[i-1]),
        .prev_found (found_w[i-1]),
        .prev_best  (best_w[i-1]),
        .value      (val_w[i]),
        .found      (found_w[i]),
        .best       (best_w[i])
      );
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_shift_in_scan: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |-> !busy)
    else $error("insert shift during a query scan");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag)
    else $error("overflow flag cleared");

  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result without a completed scan");

endmodule
`default_nettype wire

[verif/tb_sequence_insert_range_max_core.sv]
`timescale 1ns / 100ps
module tb_sequence_insert_range_max_core;
  import sirm_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1630;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int IDLE_PCT     = 7;
  localparam int HOLD_CYCLES  = 1500;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // directed rows either carry a hand-written result or defer to the predictor
  localparam logic BY_HAND  = 1'b1;
  localparam logic BY_MODEL = 1'b0;

  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // predictor state
  logic signed [31:0] seq_vals [CAP];
  int                 seq_len = 0;
  logic               seq_ovf = 1'b0;

  out_beat_t pending_max_q [$];
  dir_row_t  dir_rows [$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  bit        calm        = 1'b0;

  always #4 clk = ~clk;

  sequence_insert_range_max_core #(
    .CAPACITY (CAP)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  function automatic void seq_insert(logic signed [31:0] val, logic [9:0] pos_in);
    int p;
    if (seq_len >= CAP) begin
      seq_ovf = 1'b1;
      return;
    end
    p = int'(pos_in);
    if (p < 1) p = 1;
    if (p > seq_len + 1) p = seq_len + 1;
    for (int i = seq_len; i > p - 1; i--) seq_vals[i] = seq_vals[i-1];
    seq_vals[p-1] = val;
    seq_len++;
  endfunction

  function automatic logic signed [31:0] seq_range_max(logic [9:0] lo_in, logic [9:0] hi_in);
    int                 lo;
    int                 hi;
    logic signed [31:0] best;
    lo = int'(lo_in);
    hi = int'(hi_in);
    if (lo < 1) lo = 1;
    if (hi > seq_len) hi = seq_len;
    best = EMPTY_MAX;
    for (int i = lo; i <= hi; i++) begin
      if (i == lo || seq_vals[i-1] > best) best = seq_vals[i-1];
    end
    return best;
  endfunction

  function automatic dir_row_t row(logic cmd, logic signed [31:0] val, logic [9:0] pos,
                                   logic [9:0] lo, logic [9:0] hi, logic typed,
                                   logic signed [31:0] want_max);
    dir_row_t r;
    r.beat.cmd        = cmd;
    r.beat.value      = val;
    r.beat.position   = pos;
    r.beat.range_low  = lo;
    r.beat.range_high = hi;
    r.typed           = typed;
    r.want.max_value  = want_max;
    r.want.overflow   = 1'b0;
    return r;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int       span;
    int       pick;
    b.value      = $urandom;
    b.position   = 10'($urandom);
    b.range_low  = 10'($urandom);
    b.range_high = 10'($urandom);
    // fewer inserts once the store is full, they are only dropped there
    b.cmd  = ($urandom_range(99) < ((seq_len < CAP) ? 50 : 70)) ? CMD_QUERY : CMD_INSERT;
    span = seq_len + 2;
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(5))
        0:       b.value = VAL_MIN;
        1:       b.value = VAL_MAX;
        2:       b.value = EMPTY_MAX;
        3:       b.value = EMPTY_MAX - 32'sd1;
        4:       b.value = '0;
        default: b.value = $urandom_range(15) - 8;
      endcase
    end
    if (b.cmd == CMD_INSERT) begin
      pick = $urandom_range(99);
      if (pick < 70) b.position = 10'($urandom_range(span));
      else if (pick < 80) b.position = '0;
      else if (pick < 90) b.position = 10'd1023;
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        b.range_low  = 10'($urandom_range(span));
        b.range_high = 10'(int'(b.range_low) + $urandom_range(span - int'(b.range_low)));
      end else if (pick < 60) begin
        b.range_low  = 10'($urandom_range(span));
        b.range_high = b.range_low;
      end else if (pick < 70) begin
        b.range_low  = '0;
        b.range_high = 10'd1023;
      end else if (pick < 80) begin
        b.range_high = 10'($urandom_range(span));
        b.range_low  = 10'(int'(b.range_high) + 1 + $urandom_range(5));
      end
    end
    return b;
  endfunction

  task automatic drive_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    out_beat_t exp_beat;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.cmd == CMD_INSERT) begin
      seq_insert(b.value, b.position);
    end else begin
      if (typed) begin
        exp_beat = want;
      end else begin
        exp_beat.max_value = seq_range_max(b.range_low, b.range_high);
        exp_beat.overflow  = seq_ovf;
      end
      pending_max_q.push_back(exp_beat);
    end
  endtask

  task automatic check_max(input out_beat_t got);
    out_beat_t want;
    if (pending_max_q.size() == 0) begin
      $error("result beat with nothing pending: max_value %0d overflow %0b",
             got.max_value, got.overflow);
      fail_count++;
      return;
    end
    want = pending_max_q.pop_front();
    if (got.max_value !== want.max_value) begin
      $error("max_value expected %0d actual %0d", want.max_value, got.max_value);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow expected %0b actual %0b", want.overflow, got.overflow);
      fail_count++;
    end
  endtask

  initial begin : result_side
    int   hold_left;
    int   results_taken;
    bit   held;
    logic nxt_stall;
    hold_left     = 0;
    results_taken = 0;
    held          = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        check_max(out_beat);
        results_taken++;
        // long hold-off: sender keeps offering, input backs up
        if (results_taken == 20 && !held) begin
          held      = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        nxt_stall = 1'b1;
        hold_left--;
      end else begin
        nxt_stall = !calm && ($urandom_range(99) < IDLE_PCT);
      end
      out_stall <= nxt_stall;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sequence_insert_range_max_core: FAIL");
    $finish;
  end

  initial begin : stimulus
    // empty store
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd0,    10'd1023, BY_HAND,  EMPTY_MAX));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd1,    10'd1,    BY_HAND,  EMPTY_MAX));
    dir_rows.push_back(row(CMD_QUERY,  VAL_MAX,  10'd1023, 10'd1023, 10'd0,    BY_HAND,  EMPTY_MAX));
    // position 0 acts as 1, values below the empty marker still count
    dir_rows.push_back(row(CMD_INSERT, VAL_MIN,  10'd0,    10'd1023, 10'd1023, BY_HAND,  '0));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd0,    10'd1023, BY_HAND,  VAL_MIN));
    // position past the end appends
    dir_rows.push_back(row(CMD_INSERT, VAL_MAX,  10'd1023, 10'd0,    10'd0,    BY_HAND,  '0));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd1,    10'd1,    BY_HAND,  VAL_MIN));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd2,    10'd2,    BY_HAND,  VAL_MAX));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd2,    10'd1,    BY_HAND,  EMPTY_MAX));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd3,    10'd1023, BY_HAND,  EMPTY_MAX));
    // sequence becomes  E-1, MIN, E, MAX
    dir_rows.push_back(row(CMD_INSERT, EMPTY_MAX, 10'd2,   10'd0,    10'd0,    BY_HAND,  '0));
    dir_rows.push_back(row(CMD_INSERT, EMPTY_MAX - 32'sd1, 10'd1, 10'd0, 10'd0, BY_HAND, '0));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd1,    10'd2,    BY_HAND,
                           EMPTY_MAX - 32'sd1));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd0,    10'd3,    BY_HAND,  EMPTY_MAX));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd0,    10'd1023, BY_HAND,  VAL_MAX));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd0,    10'd0,    BY_HAND,  EMPTY_MAX));
    dir_rows.push_back(row(CMD_INSERT, '0,       10'd3,    10'd5,    10'd9,    BY_MODEL, '0));
    dir_rows.push_back(row(CMD_INSERT, -32'sd1,  10'd5,    10'd0,    10'd0,    BY_MODEL, '0));
    dir_rows.push_back(row(CMD_INSERT, 32'sh1234_5678, 10'd1, 10'd0, 10'd0,    BY_MODEL, '0));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd2,    10'd5,    BY_MODEL, '0));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd4,    10'd4,    BY_MODEL, '0));
    dir_rows.push_back(row(CMD_INSERT, 32'shfff0_0000, 10'd7, 10'd0, 10'd0,    BY_MODEL, '0));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd6,    10'd1023, BY_MODEL, '0));
    dir_rows.push_back(row(CMD_QUERY,  '0,       10'd0,    10'd1,    10'd7,    BY_MODEL, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) drive_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      drive_beat(random_beat(), BY_MODEL, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_max_q.size() != 0) @(posedge clk);
    repeat (CAP + 16) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_sequence_insert_range_max_core: PASS");
    end else begin
      $display("tb_sequence_insert_range_max_core: FAIL");
    end
    $finish;
  end

endmodule
